### hdl/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the script line tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

    // default width of the line counter
    localparam int LINE_COUNT_BITS_DEF = 16;
    // width of the line number on the result port
    localparam int LINE_OUT_BITS = 16;
    // most results one source byte can cause
    localparam int MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TEND = 2'd1,
        KIND_LEND = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        TOK_WORD = 2'd0,
        TOK_NUM  = 2'd1,
        TOK_STR  = 2'd2,
        TOK_SYM  = 2'd3
    } tok_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] lex_byte;
        tok_t       tok;
        logic       err;
        logic       done;
    } result_t;

    // all results of one source byte; they share one line number
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                count;
        logic [LINE_OUT_BITS-1:0]  line;
    } bundle_t;

endpackage

### hdl/slt_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_lexer
// Comment filter, token splitter and number recognizer state; builds the
// result bundle of the byte in the input register in one pass.
// ----------------------------------------------------------------------------
module slt_lexer #(
    parameter int LINE_COUNT_BITS = slt_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        char_in,
    input  logic              eos_in,
    output slt_pkg::bundle_t  bundle
);

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LF_L   = 8'h66;
    localparam logic [7:0] CH_LI     = 8'h69;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LP     = 8'h70;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LY     = 8'h79;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STR,
        MODE_ESC
    } mode_t;

    // strtod full-match recognizer
    typedef enum logic [4:0] {
        R_START, R_SIGN, R_ZERO, R_DEC, R_E, R_ES, R_EDIG,
        R_HX, R_HDIG, R_P, R_PS, R_PDIG,
        R_I, R_IN, R_INF, R_INFI, R_INFIN, R_INFINI, R_INFINIT, R_INFINITY,
        R_N, R_NA, R_NAN, R_DEAD
    } rec_t;

    function automatic rec_t rec_lead(input logic [7:0] c, input logic [7:0] lc);
        rec_t r;
        if (c == CH_ZERO)
            r = R_ZERO;
        else if (c >= CH_ONE && c <= CH_NINE)
            r = R_DEC;
        else if (lc == CH_LI)
            r = R_I;
        else if (lc == CH_LN)
            r = R_N;
        else
            r = R_DEAD;
        return r;
    endfunction

    function automatic rec_t rec_next(input rec_t s, input logic [7:0] c);
        logic [7:0] lc;
        logic       dig;
        logic       hex;
        logic       sgn;
        rec_t       r;
        lc  = c | 8'h20;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        hex = dig || ((lc >= CH_LA) && (lc <= CH_LF_L));
        sgn = (c == CH_PLUS) || (c == CH_MINUS);
        case (s)
            R_START:  r = sgn ? R_SIGN : rec_lead(c, lc);
            R_SIGN:   r = rec_lead(c, lc);
            R_ZERO:   r = dig ? R_DEC : (lc == CH_LX) ? R_HX : (lc == CH_LE) ? R_E : R_DEAD;
            R_DEC:    r = dig ? R_DEC : (lc == CH_LE) ? R_E : R_DEAD;
            R_E:      r = sgn ? R_ES : dig ? R_EDIG : R_DEAD;
            R_ES,
            R_EDIG:   r = dig ? R_EDIG : R_DEAD;
            R_HX:     r = hex ? R_HDIG : R_DEAD;
            R_HDIG:   r = hex ? R_HDIG : (lc == CH_LP) ? R_P : R_DEAD;
            R_P:      r = sgn ? R_PS : dig ? R_PDIG : R_DEAD;
            R_PS,
            R_PDIG:   r = dig ? R_PDIG : R_DEAD;
            R_I:      r = (lc == CH_LN) ? R_IN : R_DEAD;
            R_IN:     r = (lc == CH_LF_L) ? R_INF : R_DEAD;
            R_INF:    r = (lc == CH_LI) ? R_INFI : R_DEAD;
            R_INFI:   r = (lc == CH_LN) ? R_INFIN : R_DEAD;
            R_INFIN:  r = (lc == CH_LI) ? R_INFINI : R_DEAD;
            R_INFINI: r = (lc == CH_LT) ? R_INFINIT : R_DEAD;
            R_INFINIT: r = (lc == CH_LY) ? R_INFINITY : R_DEAD;
            R_N:      r = (lc == CH_LA) ? R_NA : R_DEAD;
            R_NA:     r = (lc == CH_LN) ? R_NAN : R_DEAD;
            default:  r = R_DEAD;
        endcase
        return r;
    endfunction

    function automatic logic rec_accepts(input rec_t s);
        return (s == R_ZERO) || (s == R_DEC) || (s == R_EDIG) || (s == R_HDIG) ||
               (s == R_PDIG) || (s == R_INF) || (s == R_INFINITY) || (s == R_NAN);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c inside {CH_LPAREN, CH_RPAREN, CH_COMMA, CH_PERIOD};
    endfunction

    function automatic slt_pkg::result_t mk(input slt_pkg::kind_t k, input logic [7:0] b,
                                            input slt_pkg::tok_t t, input logic e,
                                            input logic d);
        slt_pkg::result_t r;
        r.kind     = k;
        r.lex_byte = b;
        r.tok      = t;
        r.err      = e;
        r.done     = d;
        return r;
    endfunction

    // state
    logic                       quote_reg, quote_next;
    logic                       bslash_reg, bslash_next;
    logic                       comment_reg, comment_next;
    mode_t                      mode_reg, mode_next;
    rec_t                       rec_reg, rec_next_v;
    logic [LINE_COUNT_BITS-1:0] line_reg, line_next;

    localparam int LINE_OUT_BITS_L = slt_pkg::LINE_OUT_BITS;
    logic [LINE_OUT_BITS_L-1:0] line_out;

    generate
        if (LINE_COUNT_BITS > LINE_OUT_BITS_L) begin : g_sat
            assign line_out = (|line_reg[LINE_COUNT_BITS-1:LINE_OUT_BITS_L]) ?
                              '1 : line_reg[LINE_OUT_BITS_L-1:0];
        end else begin : g_ext
            assign line_out = LINE_OUT_BITS_L'(line_reg);
        end
    endgenerate

    logic                 eos;
    logic                 pass;
    logic [1:0]           n;
    slt_pkg::tok_t        word_tok;
    slt_pkg::result_t [slt_pkg::MAX_RESULTS-1:0] res;
    logic [7:0]           esc_byte;

    always_comb
    begin
        quote_next   = quote_reg;
        bslash_next  = bslash_reg;
        comment_next = comment_reg;
        mode_next    = mode_reg;
        rec_next_v   = rec_reg;
        line_next    = line_reg;
        res          = '0;
        n            = 2'd0;
        pass         = 1'b1;
        eos          = eos_in || (char_in == 8'h00);
        word_tok     = rec_accepts(rec_reg) ? slt_pkg::TOK_NUM : slt_pkg::TOK_WORD;
        esc_byte     = (char_in == CH_LN) ? CH_LF : (char_in == CH_LT) ? CH_TAB : char_in;

        if (eos || char_in == CH_LF) begin
            if (mode_reg == MODE_STR || mode_reg == MODE_ESC) begin
                res[n] = mk(slt_pkg::KIND_ERR, 8'h00, slt_pkg::TOK_WORD, 1'b1, 1'b1);
                n      = n + 2'd1;
                line_next = LINE_COUNT_BITS'(1);
            end else begin
                if (mode_reg == MODE_WORD) begin
                    res[n] = mk(slt_pkg::KIND_TEND, 8'h00, word_tok, 1'b0, 1'b0);
                    n      = n + 2'd1;
                end
                res[n] = mk(slt_pkg::KIND_LEND, 8'h00, slt_pkg::TOK_WORD, 1'b0, eos);
                n      = n + 2'd1;
                if (eos)
                    line_next = LINE_COUNT_BITS'(1);
                else if (line_reg != '1)
                    line_next = line_reg + LINE_COUNT_BITS'(1);
            end
            quote_next   = 1'b0;
            bslash_next  = 1'b0;
            comment_next = 1'b0;
            mode_next    = MODE_IDLE;
            rec_next_v   = R_START;
        end else if (!comment_reg) begin
            if (char_in == CH_QUOTE && !bslash_reg) begin
                quote_next = !quote_reg;
            end else if (!quote_reg && char_in == CH_HASH) begin
                comment_next = 1'b1;
                pass         = 1'b0;
                if (mode_reg == MODE_WORD) begin
                    res[n]     = mk(slt_pkg::KIND_TEND, 8'h00, word_tok, 1'b0, 1'b0);
                    n          = n + 2'd1;
                    mode_next  = MODE_IDLE;
                    rec_next_v = R_START;
                end
            end
            bslash_next = (char_in == CH_BSLASH);

            if (pass) begin
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (is_blank(char_in)) begin
                            mode_next = MODE_IDLE;
                        end else if (char_in == CH_QUOTE) begin
                            mode_next = MODE_STR;
                        end else if (is_symbol(char_in)) begin
                            res[n] = mk(slt_pkg::KIND_BYTE, char_in, slt_pkg::TOK_WORD,
                                        1'b0, 1'b0);
                            n      = n + 2'd1;
                            res[n] = mk(slt_pkg::KIND_TEND, 8'h00, slt_pkg::TOK_SYM,
                                        1'b0, 1'b0);
                            n      = n + 2'd1;
                        end else begin
                            mode_next  = MODE_WORD;
                            rec_next_v = rec_next(R_START, char_in);
                            res[n] = mk(slt_pkg::KIND_BYTE, char_in, slt_pkg::TOK_WORD,
                                        1'b0, 1'b0);
                            n      = n + 2'd1;
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_blank(char_in) || is_symbol(char_in)) begin
                            res[n] = mk(slt_pkg::KIND_TEND, 8'h00, word_tok, 1'b0, 1'b0);
                            n      = n + 2'd1;
                            mode_next  = MODE_IDLE;
                            rec_next_v = R_START;
                            if (is_symbol(char_in)) begin
                                res[n] = mk(slt_pkg::KIND_BYTE, char_in, slt_pkg::TOK_WORD,
                                            1'b0, 1'b0);
                                n      = n + 2'd1;
                                res[n] = mk(slt_pkg::KIND_TEND, 8'h00, slt_pkg::TOK_SYM,
                                            1'b0, 1'b0);
                                n      = n + 2'd1;
                            end
                        end else begin
                            rec_next_v = rec_next(rec_reg, char_in);
                            res[n] = mk(slt_pkg::KIND_BYTE, char_in, slt_pkg::TOK_WORD,
                                        1'b0, 1'b0);
                            n      = n + 2'd1;
                        end
                    end
                    MODE_STR:
                    begin
                        if (char_in == CH_QUOTE) begin
                            res[n] = mk(slt_pkg::KIND_TEND, 8'h00, slt_pkg::TOK_STR,
                                        1'b0, 1'b0);
                            n      = n + 2'd1;
                            mode_next = MODE_IDLE;
                        end else if (char_in == CH_BSLASH) begin
                            mode_next = MODE_ESC;
                        end else begin
                            res[n] = mk(slt_pkg::KIND_BYTE, char_in, slt_pkg::TOK_WORD,
                                        1'b0, 1'b0);
                            n      = n + 2'd1;
                        end
                    end
                    default:
                    begin
                        res[n] = mk(slt_pkg::KIND_BYTE, esc_byte, slt_pkg::TOK_WORD,
                                    1'b0, 1'b0);
                        n      = n + 2'd1;
                        mode_next = MODE_STR;
                    end
                endcase
            end
        end
    end

    assign bundle.res   = res;
    assign bundle.count = n;
    assign bundle.line  = line_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            quote_reg   <= 1'b0;
            bslash_reg  <= 1'b0;
            comment_reg <= 1'b0;
            mode_reg    <= MODE_IDLE;
            rec_reg     <= R_START;
            line_reg    <= LINE_COUNT_BITS'(1);
        end else if (step) begin
            quote_reg   <= quote_next;
            bslash_reg  <= bslash_next;
            comment_reg <= comment_next;
            mode_reg    <= mode_next;
            rec_reg     <= rec_next_v;
            line_reg    <= line_next;
        end
    end

endmodule

### hdl/slt_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_outbuf
// Result register: holds one bundle and hands its results out one word
// at a time.
// ----------------------------------------------------------------------------
module slt_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  slt_pkg::bundle_t  bundle,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output slt_pkg::result_t  res,
    output logic [slt_pkg::LINE_OUT_BITS-1:0] line,
    output logic              last
);

    slt_pkg::bundle_t bundle_reg;
    logic             valid_reg;
    logic [1:0]       idx_reg;

    assign out_valid = valid_reg;
    assign res       = bundle_reg.res[idx_reg];
    assign line      = bundle_reg.line;
    assign last      = (idx_reg == (bundle_reg.count - 2'd1));
    assign free      = !valid_reg || (out_ready && last);

    always_ff @(posedge clk)
    begin
        if (load)
            bundle_reg <= bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (valid_reg && out_ready) begin
            if (last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

### hdl/script_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_line_tokenizer
// Streaming tokenizer for a line-oriented script: comment filter, token
// splitter with string escapes, and number/word typing of each word.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | word contents
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | char_byte, end_of_source
//  out     | out_valid/out_ready| kind, lexeme_byte, token_type, line_no,
//          |                    | error_code, source_done, last_of_run
//
//  One source byte per cycle while the result register keeps up. A byte is
//  latched in the input register, the lexer builds its bundle of 0..3
//  results in one pass into the result register, and results leave one
//  word per cycle while out_ready holds; a byte with results waits in the
//  input register until the result register is free for its bundle.
//  Reset clears all tokenizer state; line counting starts at one.
//  A stall on out holds the result register and, one byte later, in_ready.
//
module script_line_tokenizer #(
    parameter int LINE_COUNT_BITS = slt_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        end_of_source,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  lexeme_byte,
    output logic [1:0]  token_type,
    output logic [15:0] line_no,
    output logic        error_code,
    output logic        source_done,
    output logic        last_of_run
);

    // input register
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       eos_reg;

    slt_pkg::bundle_t bundle;
    slt_pkg::result_t cur_res;
    logic             buf_free;
    logic             advance;
    logic             load;

    // the held byte moves on when its results fit in the result register;
    // bytes with no results (blanks, comment text) move on at once
    assign advance  = in_valid_reg && ((bundle.count == 2'd0) || buf_free);
    assign load     = advance && (bundle.count != 2'd0);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            char_reg <= char_byte;
            eos_reg  <= end_of_source;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    slt_lexer #(
        .LINE_COUNT_BITS(LINE_COUNT_BITS)
    ) u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .char_in (char_reg),
        .eos_in  (eos_reg),
        .bundle  (bundle)
    );

    slt_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .bundle    (bundle),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (cur_res),
        .line      (line_no),
        .last      (last_of_run)
    );

    assign kind        = cur_res.kind;
    assign lexeme_byte = cur_res.lex_byte;
    assign token_type  = cur_res.tok;
    assign error_code  = cur_res.err;
    assign source_done = cur_res.done;

    // an error word stands alone and closes the source
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == slt_pkg::KIND_ERR) |-> (last_of_run && source_done && error_code))
        else $error("error word not alone or not closing the source");

    // the final line end is the last word of its byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && source_done) |-> last_of_run)
        else $error("source_done on a word that is not last of its run");

    // token type only on token ends
    a_type_tend: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != slt_pkg::KIND_TEND) |-> (token_type == slt_pkg::TOK_WORD))
        else $error("token_type set on a word that is not a token end");

    // a byte is never taken while the held one still waits
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !in_ready)
        else $error("input register overrun");

endmodule

### sim/tb_script_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_script_line_tokenizer
// Self-checking bench for the script line tokenizer. A directed walk through
// comments, strings, numbers and source ends is followed by random lines of
// well-formed tokens mixed with noise and broken strings, then a short run of
// empty lines and a last token line at full rate. Every result word is checked
// against a behavioral tokenizer kept inside the bench.
// ----------------------------------------------------------------------------
module tb_script_line_tokenizer;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int ITEMS_TARGET  = 370;
    localparam int HOLD_CYCLES   = 90;     // long output stall
    localparam int TAIL_LINES    = 4;      // empty lines sent at full rate
    localparam int TAIL_ITEMS    = TAIL_LINES + 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int DRAIN_TAIL    = 8;      // margin for the input and result registers plus a full bundle
    localparam int MAX_REPORTS   = 40;
    localparam longint LIMIT_NS  = 64'd6_000_000;
    localparam int LCB           = slt_pkg::LINE_COUNT_BITS_DEF;
    localparam longint LINE_MAX  = (longint'(1) << LCB) - 1;

    // byte codes with a meaning to the tokenizer
    localparam logic [7:0] NUL_CH    = 8'h00;
    localparam logic [7:0] TAB_CH    = 8'h09;
    localparam logic [7:0] LF_CH     = 8'h0A;
    localparam logic [7:0] VT_CH     = 8'h0B;
    localparam logic [7:0] FF_CH     = 8'h0C;
    localparam logic [7:0] CR_CH     = 8'h0D;
    localparam logic [7:0] SPACE_CH  = 8'h20;
    localparam logic [7:0] QUOTE_CH  = 8'h22;
    localparam logic [7:0] HASH_CH   = 8'h23;
    localparam logic [7:0] LPAREN_CH = 8'h28;
    localparam logic [7:0] RPAREN_CH = 8'h29;
    localparam logic [7:0] COMMA_CH  = 8'h2C;
    localparam logic [7:0] PERIOD_CH = 8'h2E;
    localparam logic [7:0] BSLASH_CH = 8'h5C;

    localparam string WORD_POOL = "abcdefghxyzINFNAtpy_019+-!$@";

    typedef enum logic [1:0] {LX_IDLE, LX_WORD, LX_STR, LX_ESC} lex_mode_t;

    // states of the strtod-style number matcher
    typedef enum logic [4:0] {
        NR_START, NR_SIGN, NR_ZERO, NR_DEC, NR_E, NR_ES, NR_EDIG,
        NR_HX, NR_HDIG, NR_P, NR_PS, NR_PDIG,
        NR_I, NR_IN, NR_INF, NR_INFI, NR_INFIN, NR_INFINI, NR_INFINIT, NR_INFINITY,
        NR_N, NR_NA, NR_NAN, NR_DEAD
    } num_state_t;

    typedef struct packed {
        slt_pkg::kind_t kind;
        logic [7:0]     lex;
        slt_pkg::tok_t  tok;
        logic [15:0]    line;
        logic           err;
        logic           done;
        logic           last;
    } token_word_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eos;
        logic        typed;
        token_word_t want;
    } dir_row_t;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_byte;
    logic        end_of_source;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  lexeme_byte;
    logic [1:0]  token_type;
    logic [15:0] line_no;
    logic        error_code;
    logic        source_done;
    logic        last_of_run;

    script_line_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_byte     (char_byte),
        .end_of_source (end_of_source),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .lexeme_byte   (lexeme_byte),
        .token_type    (token_type),
        .line_no       (line_no),
        .error_code    (error_code),
        .source_done   (source_done),
        .last_of_run   (last_of_run)
    );

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    token_word_t tokens_due[$];     // expected words, oldest first
    dir_row_t    dir_rows[$];
    logic [7:0]  line_q[$];         // bytes of the random line being built

    int  fail_count   = 0;
    int  report_count = 0;
    int  words_seen   = 0;
    int  err_words    = 0;
    int  bytes_sent   = 0;
    int  bytes_live   = 0;          // bytes not swallowed by a comment
    bit  tx_quiet;
    bit  rx_quiet;
    bit  hold_request;

    // tokenizer image kept by the bench
    logic       q_open;             // comment filter sits inside quotes
    logic       after_bslash;
    logic       skipping_comment;
    lex_mode_t  lx_mode;
    num_state_t nr_state;
    longint     line_cnt;

    token_word_t step_buf [slt_pkg::MAX_RESULTS];
    int          step_n;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Behavioral tokenizer
    // ------------------------------------------------------------------
    function automatic num_state_t num_lead(logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (c == "0") return NR_ZERO;
        if (c >= "1" && c <= "9") return NR_DEC;
        if (lc == "i") return NR_I;
        if (lc == "n") return NR_N;
        return NR_DEAD;
    endfunction

    function automatic num_state_t num_advance(num_state_t s, logic [7:0] c);
        logic [7:0] lc;
        logic       dig;
        logic       hexd;
        logic       sgn;
        lc   = c | 8'h20;
        dig  = (c >= "0" && c <= "9");
        hexd = dig || (lc >= "a" && lc <= "f");
        sgn  = (c == "+" || c == "-");
        case (s)
            NR_START:         return sgn ? NR_SIGN : num_lead(c);
            NR_SIGN:          return num_lead(c);
            NR_ZERO:          return dig ? NR_DEC : lc == "x" ? NR_HX : lc == "e" ? NR_E : NR_DEAD;
            NR_DEC:           return dig ? NR_DEC : lc == "e" ? NR_E : NR_DEAD;
            NR_E:             return sgn ? NR_ES : dig ? NR_EDIG : NR_DEAD;
            NR_ES, NR_EDIG:   return dig ? NR_EDIG : NR_DEAD;
            NR_HX:            return hexd ? NR_HDIG : NR_DEAD;
            NR_HDIG:          return hexd ? NR_HDIG : lc == "p" ? NR_P : NR_DEAD;
            NR_P:             return sgn ? NR_PS : dig ? NR_PDIG : NR_DEAD;
            NR_PS, NR_PDIG:   return dig ? NR_PDIG : NR_DEAD;
            NR_I:             return lc == "n" ? NR_IN : NR_DEAD;
            NR_IN:            return lc == "f" ? NR_INF : NR_DEAD;
            NR_INF:           return lc == "i" ? NR_INFI : NR_DEAD;
            NR_INFI:          return lc == "n" ? NR_INFIN : NR_DEAD;
            NR_INFIN:         return lc == "i" ? NR_INFINI : NR_DEAD;
            NR_INFINI:        return lc == "t" ? NR_INFINIT : NR_DEAD;
            NR_INFINIT:       return lc == "y" ? NR_INFINITY : NR_DEAD;
            NR_N:             return lc == "a" ? NR_NA : NR_DEAD;
            NR_NA:            return lc == "n" ? NR_NAN : NR_DEAD;
            default:          return NR_DEAD;
        endcase
    endfunction

    function automatic bit num_complete(num_state_t s);
        return s inside {NR_ZERO, NR_DEC, NR_EDIG, NR_HDIG, NR_PDIG,
                         NR_INF, NR_INFINITY, NR_NAN};
    endfunction

    function automatic bit is_gap(logic [7:0] c);
        return c == SPACE_CH || c == TAB_CH || c == VT_CH || c == FF_CH || c == CR_CH;
    endfunction

    function automatic bit is_punct(logic [7:0] c);
        return c == LPAREN_CH || c == RPAREN_CH || c == COMMA_CH || c == PERIOD_CH;
    endfunction

    function automatic void restart_source();
        q_open           = 1'b0;
        after_bslash     = 1'b0;
        skipping_comment = 1'b0;
        lx_mode          = LX_IDLE;
        nr_state         = NR_START;
        line_cnt         = 1;
    endfunction

    function automatic void emit(slt_pkg::kind_t k, logic [7:0] b, slt_pkg::tok_t t,
                                 logic e, logic d);
        token_word_t w;
        w      = '0;
        w.kind = k;
        w.lex  = b;
        w.tok  = t;
        w.line = (line_cnt > 65535) ? 16'hFFFF : 16'(line_cnt);
        w.err  = e;
        w.done = d;
        step_buf[step_n] = w;
        step_n++;
    endfunction

    function automatic void close_word();
        emit(slt_pkg::KIND_TEND, 8'h00,
             num_complete(nr_state) ? slt_pkg::TOK_NUM : slt_pkg::TOK_WORD, 1'b0, 1'b0);
        lx_mode  = LX_IDLE;
        nr_state = NR_START;
    endfunction

    function automatic void emit_symbol(logic [7:0] c);
        emit(slt_pkg::KIND_BYTE, c, slt_pkg::TOK_WORD, 1'b0, 1'b0);
        emit(slt_pkg::KIND_TEND, 8'h00, slt_pkg::TOK_SYM, 1'b0, 1'b0);
    endfunction

    function automatic void lex_char(logic [7:0] c);
        case (lx_mode)
            LX_IDLE:
            begin
                if (is_gap(c)) return;
                if (c == QUOTE_CH)
                begin
                    lx_mode = LX_STR;
                end
                else if (is_punct(c))
                begin
                    emit_symbol(c);
                end
                else
                begin
                    lx_mode  = LX_WORD;
                    nr_state = num_advance(NR_START, c);
                    emit(slt_pkg::KIND_BYTE, c, slt_pkg::TOK_WORD, 1'b0, 1'b0);
                end
            end
            LX_WORD:
            begin
                if (is_gap(c))
                begin
                    close_word();
                end
                else if (is_punct(c))
                begin
                    close_word();
                    emit_symbol(c);
                end
                else
                begin
                    nr_state = num_advance(nr_state, c);
                    emit(slt_pkg::KIND_BYTE, c, slt_pkg::TOK_WORD, 1'b0, 1'b0);
                end
            end
            LX_STR:
            begin
                if (c == QUOTE_CH)
                begin
                    emit(slt_pkg::KIND_TEND, 8'h00, slt_pkg::TOK_STR, 1'b0, 1'b0);
                    lx_mode = LX_IDLE;
                end
                else if (c == BSLASH_CH)
                begin
                    lx_mode = LX_ESC;
                end
                else
                begin
                    emit(slt_pkg::KIND_BYTE, c, slt_pkg::TOK_WORD, 1'b0, 1'b0);
                end
            end
            default:
            begin
                emit(slt_pkg::KIND_BYTE, c == "n" ? LF_CH : c == "t" ? TAB_CH : c,
                     slt_pkg::TOK_WORD, 1'b0, 1'b0);
                lx_mode = LX_STR;
            end
        endcase
    endfunction

    // Fills step_buf with the words one source byte causes.
    // Returns 1 when the byte fell inside a comment and changed nothing.
    function automatic bit tokenize_byte(logic [7:0] c, logic eos_flag);
        logic eos;
        bit   pass;
        bit   swallowed;
        eos       = eos_flag || c == NUL_CH;
        step_n    = 0;
        swallowed = 1'b0;
        if (eos || c == LF_CH)
        begin
            if (lx_mode == LX_STR || lx_mode == LX_ESC)
            begin
                // string still open at line end
                emit(slt_pkg::KIND_ERR, 8'h00, slt_pkg::TOK_WORD, 1'b1, 1'b1);
                restart_source();
            end
            else
            begin
                if (lx_mode == LX_WORD) close_word();
                emit(slt_pkg::KIND_LEND, 8'h00, slt_pkg::TOK_WORD, 1'b0, eos);
                if (eos)
                begin
                    restart_source();
                end
                else
                begin
                    if (line_cnt < LINE_MAX) line_cnt++;
                    q_open           = 1'b0;
                    after_bslash     = 1'b0;
                    skipping_comment = 1'b0;
                    lx_mode          = LX_IDLE;
                    nr_state         = NR_START;
                end
            end
        end
        else if (!skipping_comment)
        begin
            pass = 1'b1;
            if (c == QUOTE_CH && !after_bslash)
            begin
                q_open = ~q_open;
            end
            else if (!q_open && c == HASH_CH)
            begin
                skipping_comment = 1'b1;
                pass             = 1'b0;
                if (lx_mode == LX_WORD) close_word();
            end
            after_bslash = (c == BSLASH_CH);
            if (pass) lex_char(c);
        end
        else
        begin
            swallowed = 1'b1;
        end
        if (step_n > 0) step_buf[step_n-1].last = 1'b1;
        return swallowed;
    endfunction

    function automatic void push_step();
        for (int i = 0; i < step_n; i++) tokens_due.push_back(step_buf[i]);
    endfunction

    // ------------------------------------------------------------------
    // Idle pattern: mostly none, often short, now and then long
    // ------------------------------------------------------------------
    function automatic int idle_len(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one word and return at the edge that accepts it.
    task automatic feed(input logic [7:0] c, input logic eos);
        int gap;
        gap = idle_len(tx_quiet);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        char_byte     <= c;
        end_of_source <= eos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic eos);
        feed(c, eos);
        if (!tokenize_byte(c, eos)) bytes_live++;
        push_step();
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure plus one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : sink
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                stall = idle_len(rx_quiet);
                if (stall == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic bit same(string what, logic [15:0] want, logic [15:0] got);
        if (got === want) return 1'b1;
        if (report_count < MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
        report_count++;
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin : out_check
        token_word_t w;
        bit          ok;
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (kind == slt_pkg::KIND_ERR) err_words++;
            if (tokens_due.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                    $display("%0t: unexpected result word: expected none, got kind %0h byte %0h",
                             $time, kind, lexeme_byte);
                report_count++;
            end
            else
            begin
                w  = tokens_due.pop_front();
                ok = same("kind", 16'(w.kind), 16'(kind))
                   & same("lexeme_byte", 16'(w.lex), 16'(lexeme_byte))
                   & same("token_type", 16'(w.tok), 16'(token_type))
                   & same("line_no", w.line, line_no)
                   & same("error_code", 16'(w.err), 16'(error_code))
                   & same("source_done", 16'(w.done), 16'(source_done))
                   & same("last_of_run", 16'(w.last), 16'(last_of_run));
                if (!ok) fail_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed rows
    // ------------------------------------------------------------------
    function automatic dir_row_t plain_row(logic [7:0] c);
        dir_row_t r;
        r    = '0;
        r.ch = c;
        return r;
    endfunction

    // row whose single result word is known by inspection
    function automatic dir_row_t fixed_row(logic [7:0] c, logic eos, slt_pkg::kind_t k,
                                           logic [7:0] b, slt_pkg::tok_t t, logic [15:0] ln,
                                           logic e, logic d);
        dir_row_t r;
        r           = '0;
        r.ch        = c;
        r.eos       = eos;
        r.typed     = 1'b1;
        r.want.kind = k;
        r.want.lex  = b;
        r.want.tok  = t;
        r.want.line = ln;
        r.want.err  = e;
        r.want.done = d;
        r.want.last = 1'b1;
        return r;
    endfunction

    task automatic load_rows();
        // empty first line
        dir_rows.push_back(fixed_row(LF_CH, 1'b0, slt_pkg::KIND_LEND, 8'h00,
                                     slt_pkg::TOK_WORD, 16'd1, 1'b0, 1'b0));
        // line 2: top byte value as a word, ended by CR
        dir_rows.push_back(fixed_row(8'hFF, 1'b0, slt_pkg::KIND_BYTE, 8'hFF,
                                     slt_pkg::TOK_WORD, 16'd2, 1'b0, 1'b0));
        dir_rows.push_back(fixed_row(CR_CH, 1'b0, slt_pkg::KIND_TEND, 8'h00,
                                     slt_pkg::TOK_WORD, 16'd2, 1'b0, 1'b0));
        // signed hex float, closed by a comma symbol
        dir_rows.push_back(plain_row("-"));
        dir_rows.push_back(plain_row("0"));
        dir_rows.push_back(plain_row("X"));
        dir_rows.push_back(plain_row("f"));
        dir_rows.push_back(plain_row("P"));
        dir_rows.push_back(plain_row("7"));
        dir_rows.push_back(plain_row(COMMA_CH));
        // string holding a tab escape
        dir_rows.push_back(plain_row(QUOTE_CH));
        dir_rows.push_back(plain_row(BSLASH_CH));
        dir_rows.push_back(plain_row("t"));
        dir_rows.push_back(plain_row(QUOTE_CH));
        // word cut short by a comment
        dir_rows.push_back(plain_row("q"));
        dir_rows.push_back(plain_row(HASH_CH));
        dir_rows.push_back(fixed_row(LF_CH, 1'b0, slt_pkg::KIND_LEND, 8'h00,
                                     slt_pkg::TOK_WORD, 16'd2, 1'b0, 1'b0));
        // line 3: quote inside a word flips the filter, so the next quote
        // opens a string the filter sees as closed; the comment then hides
        // the rest and the line ends with the string open
        dir_rows.push_back(plain_row("a"));
        dir_rows.push_back(plain_row(QUOTE_CH));
        dir_rows.push_back(plain_row(SPACE_CH));
        dir_rows.push_back(plain_row(QUOTE_CH));
        dir_rows.push_back(plain_row(HASH_CH));
        dir_rows.push_back(fixed_row(LF_CH, 1'b0, slt_pkg::KIND_ERR, 8'h00,
                                     slt_pkg::TOK_WORD, 16'd3, 1'b1, 1'b1));
        // fresh source after the error: end flag (byte ignored), then a zero byte
        dir_rows.push_back(fixed_row(8'hFF, 1'b1, slt_pkg::KIND_LEND, 8'h00,
                                     slt_pkg::TOK_WORD, 16'd1, 1'b0, 1'b1));
        dir_rows.push_back(plain_row(PERIOD_CH));
        dir_rows.push_back(fixed_row(NUL_CH, 1'b0, slt_pkg::KIND_LEND, 8'h00,
                                     slt_pkg::TOK_WORD, 16'd1, 1'b0, 1'b1));
    endtask

    // ------------------------------------------------------------------
    // Random line builder
    // ------------------------------------------------------------------
    function automatic logic [7:0] line_byte();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == LF_CH) c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic logic [7:0] string_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 9) < 7 ? $urandom_range(32, 126) : $urandom_range(1, 255));
        while (c == LF_CH || c == QUOTE_CH || c == BSLASH_CH)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic void push_text(string s, bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (mix_case && ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z") && $urandom_range(0, 1))
                c = c ^ 8'h20;
            line_q.push_back(c);
        end
    endfunction

    function automatic void push_digits(int n, bit hexd);
        string pool;
        pool = hexd ? "0123456789abcdefABCDEF" : "0123456789";
        for (int i = 0; i < n; i++) line_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    endfunction

    function automatic void maybe_sign();
        if ($urandom_range(0, 1)) line_q.push_back($urandom_range(0, 1) ? "+" : "-");
    endfunction

    function automatic void gen_number();
        if ($urandom_range(0, 3) == 0) line_q.push_back($urandom_range(0, 1) ? "+" : "-");
        case ($urandom_range(0, 8))
            0: push_digits($urandom_range(1, 5), 1'b0);
            1:
            begin
                push_digits($urandom_range(1, 3), 1'b0);
                push_text("e", 1'b1);
                maybe_sign();
                push_digits($urandom_range(1, 3), 1'b0);
            end
            2:
            begin
                push_text("0x", 1'b1);
                push_digits($urandom_range(1, 4), 1'b1);
            end
            3:
            begin
                push_text("0x", 1'b1);
                push_digits($urandom_range(1, 3), 1'b1);
                push_text("p", 1'b1);
                maybe_sign();
                push_digits($urandom_range(1, 2), 1'b0);
            end
            4: push_text("inf", 1'b1);
            5: push_text("infinity", 1'b1);
            6: push_text("nan", 1'b1);
            7: push_text("0", 1'b0);
            default:
            begin
                // near misses
                case ($urandom_range(0, 5))
                    0: push_text("1e", 1'b1);
                    1: push_text("0x", 1'b1);
                    2: push_text("12ab", 1'b0);
                    3: push_text("0xp1", 1'b1);
                    4: push_text("infinit", 1'b1);
                    default: push_text("e5", 1'b0);
                endcase
            end
        endcase
    endfunction

    function automatic void gen_word();
        int n;
        int r;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0 && i > 0) line_q.push_back(QUOTE_CH);
            else if (r == 1) line_q.push_back(BSLASH_CH);
            else if (r == 2) line_q.push_back(8'($urandom_range(128, 255)));
            else line_q.push_back(WORD_POOL[$urandom_range(0, WORD_POOL.len() - 1)]);
        end
    endfunction

    function automatic void gen_string(bit closed);
        int n;
        n = $urandom_range(0, 6);
        line_q.push_back(QUOTE_CH);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                line_q.push_back(BSLASH_CH);
                case ($urandom_range(0, 5))
                    0: line_q.push_back("n");
                    1: line_q.push_back("t");
                    2: line_q.push_back(QUOTE_CH);
                    3: line_q.push_back(BSLASH_CH);
                    default: line_q.push_back(line_byte());
                endcase
            end
            else
            begin
                line_q.push_back(string_byte());
            end
        end
        if (closed) line_q.push_back(QUOTE_CH);
    endfunction

    function automatic void gen_blank();
        case ($urandom_range(0, 7))
            0: line_q.push_back(TAB_CH);
            1: line_q.push_back(VT_CH);
            2: line_q.push_back(FF_CH);
            3: line_q.push_back(CR_CH);
            default: line_q.push_back(SPACE_CH);
        endcase
    endfunction

    function automatic void build_line();
        int ntok;
        int pick;
        line_q.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            // pure noise
            ntok = $urandom_range(1, 12);
            for (int i = 0; i < ntok; i++) line_q.push_back(line_byte());
            return;
        end
        if ($urandom_range(0, 3) == 0) gen_blank();
        ntok = $urandom_range(0, 5);
        for (int i = 0; i < ntok; i++)
        begin
            if (i > 0 && $urandom_range(0, 3) != 0) gen_blank();
            pick = $urandom_range(0, 9);
            if (pick < 3) gen_word();
            else if (pick < 6) gen_number();
            else if (pick < 8) gen_string(1'b1);
            else
            begin
                case ($urandom_range(0, 3))
                    0: line_q.push_back(LPAREN_CH);
                    1: line_q.push_back(RPAREN_CH);
                    2: line_q.push_back(COMMA_CH);
                    default: line_q.push_back(PERIOD_CH);
                endcase
            end
        end
        if ($urandom_range(0, 19) == 0) gen_string(1'b0);     // left open
        if ($urandom_range(0, 6) == 0)
        begin
            line_q.push_back(HASH_CH);
            ntok = $urandom_range(0, 8);
            for (int i = 0; i < ntok; i++) line_q.push_back(line_byte());
        end
        if ($urandom_range(0, 4) == 0) gen_blank();
    endfunction

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    initial
    begin
        #(LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t r;
        int       term;
        int       spins;
        bit       hold_done;
        bit       pause_done;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        char_byte     = 8'h00;
        end_of_source = 1'b0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        hold_request  = 1'b0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        restart_source();
        load_rows();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk; fixed rows replace the bench's own prediction
        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            feed(r.ch, r.eos);
            if (!tokenize_byte(r.ch, r.eos)) bytes_live++;
            if (r.typed) tokens_due.push_back(r.want);
            else push_step();
        end

        // random lines
        while (bytes_sent < ITEMS_TARGET - TAIL_ITEMS)
        begin
            tx_quiet = ($urandom_range(0, 7) == 0);
            rx_quiet = ($urandom_range(0, 7) == 0);
            if (!hold_done && bytes_live > 120)
            begin
                // sink holds off while this side keeps pushing words in
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && bytes_live > 240)
            begin
                // stop and let every pending result come out
                pause_done = 1'b1;
                @(negedge clk);
                in_valid <= 1'b0;
                while (tokens_due.size() != 0) @(posedge clk);
            end
            build_line();
            foreach (line_q[i]) send_byte(line_q[i], 1'b0);
            term = $urandom_range(0, 99);
            if (term < 86) send_byte(LF_CH, 1'b0);
            else if (term < 94) send_byte(8'($urandom_range(0, 255)), 1'b1);
            else send_byte(NUL_CH, 1'b0);
        end

        // empty lines and a last token line at full rate
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        for (int i = 0; i < TAIL_LINES; i++) send_byte(LF_CH, 1'b0);
        line_q.delete();
        push_text("0x1F (", 1'b0);
        foreach (line_q[i]) send_byte(line_q[i], 1'b0);
        send_byte(LF_CH, 1'b0);
        send_byte(NUL_CH, 1'b1);

        @(negedge clk);
        in_valid <= 1'b0;

        spins = 0;
        while (tokens_due.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (DRAIN_TAIL) @(posedge clk);
        if (tokens_due.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d result words never arrived", $time, tokens_due.size());
        end

        $display("covered %0d source bytes (%0d outside comments), %0d result words checked",
                 bytes_sent, bytes_live, words_seen);
        $display("with %0d open-string errors, a %0d-cycle output hold and a drain pause",
                 err_words, HOLD_CYCLES);
        if (fail_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
